/* sv/atom_token_classifier_assert.svh */
// Assertion macros shared by the atom token classifier RTL.
`ifndef ATOM_TOKEN_CLASSIFIER_ASSERT_SVH
`define ATOM_TOKEN_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ATC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/atc_pkg.sv */
// Types, byte constants and character helpers for the atom token classifier.
package atc_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int CFG_DATA_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int STOP_CNT_BITS = 3;
    // Number of stop symbol entries reachable through the register map.
    localparam int STOP_REGS     = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STOP_COUNT = 3'd0,
        CFG_STOP_SYM_A = 3'd1,
        CFG_STOP_SYM_B = 3'd2,
        CFG_STOP_SYM_C = 3'd3,
        CFG_STOP_SYM_D = 3'd4
    } t_cfg_idx;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_SKIP = 7'b0000010,
        PH_SIGN = 7'b0000100,
        PH_INT  = 7'b0001000,
        PH_REAL = 7'b0010000,
        PH_SYM  = 7'b0100000,
        PH_DONE = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INT  = 2'd1,
        KIND_REAL = 2'd2,
        KIND_SYM  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_STOP_FIRST = 2'd2,
        ST_BAD_NUMBER = 2'd3
    } t_status;

    typedef struct packed {
        logic    emit;
        logic    success;
        t_kind   kind;
        t_status status;
        logic    inclusive;
    } t_verdict;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_kind kind_of(input t_phase ph);
        if (ph == PH_INT) begin
            return KIND_INT;
        end
        if (ph == PH_REAL) begin
            return KIND_REAL;
        end
        return KIND_SYM;
    endfunction

endpackage

/* sv/atc_if.sv */
// Byte input and token result channel interfaces.
interface atc_byte_if #(
    parameter int INDEX_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [7:0]            byte_value;
    logic [INDEX_BITS-1:0] byte_index;
    logic                  scan_begin;
    logic                  buffer_end;

    modport source (
        output valid, byte_value, byte_index, scan_begin, buffer_end,
        input  ready
    );
    modport sink (
        input  valid, byte_value, byte_index, scan_begin, buffer_end,
        output ready
    );
endinterface

interface atc_result_if #(
    parameter int INDEX_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  success;
    logic [1:0]            kind;
    logic [1:0]            status;
    logic [INDEX_BITS-1:0] scan_start_index;
    logic [INDEX_BITS-1:0] atom_start_index;
    logic [INDEX_BITS:0]   atom_length;
    logic [INDEX_BITS:0]   error_index;
    logic [INDEX_BITS:0]   next_position;

    modport source (
        output valid, success, kind, status, scan_start_index, atom_start_index,
               atom_length, error_index, next_position,
        input  ready
    );
    modport sink (
        input  valid, success, kind, status, scan_start_index, atom_start_index,
               atom_length, error_index, next_position,
        output ready
    );
endinterface

/* sv/atom_token_classifier.sv */
// Atom token classifier: input register, scan core, result register.
// The scan core updates its state in a single pass between input and result register.
// Throughput: one byte per cycle while no untaken result stalls the input register.
// Bytes that decide nothing give no result; at most one result per scan.
// Reset (i_rst_n low, synchronous) clears valid flags, scan state and config registers.
module atom_token_classifier #(
    parameter int STOP_ENTRIES = 4,
    parameter int INDEX_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    atc_byte_if.sink                          i_byte,
    atc_result_if.source                      o_tok,
    input  logic                              i_cfg_we,
    input  logic [atc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [atc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import atc_pkg::*;

`include "atom_token_classifier_assert.svh"

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [INDEX_BITS-1:0] r_in_index;
    logic                  r_in_begin;
    logic                  r_in_last;

    logic                  r_out_valid;
    logic                  r_out_success;
    t_kind                 r_out_kind;
    t_status               r_out_status;
    logic [INDEX_BITS-1:0] r_out_scan_start;
    logic [INDEX_BITS-1:0] r_out_atom_start;
    logic [INDEX_BITS:0]   r_out_atom_length;
    logic [INDEX_BITS:0]   r_out_error_index;
    logic [INDEX_BITS:0]   r_out_next_position;

    logic                  out_free;
    logic                  advance;
    logic                  is_stop;
    t_verdict              verdict;
    logic [INDEX_BITS-1:0] scan_start;
    logic [INDEX_BITS-1:0] atom_start;
    logic [INDEX_BITS:0]   atom_length;
    logic [INDEX_BITS:0]   error_index;
    logic [INDEX_BITS:0]   next_position;

    assign out_free     = !r_out_valid || o_tok.ready;
    assign advance      = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte  <= i_byte.byte_value;
            r_in_index <= i_byte.byte_index;
            r_in_begin <= i_byte.scan_begin;
            r_in_last  <= i_byte.buffer_end;
        end
    end

    atc_stop_cfg #(
        .STOP_ENTRIES (STOP_ENTRIES)
    ) u_stop_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (r_in_byte),
        .o_is_stop   (is_stop)
    );

    atc_scan_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_scan_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_byte          (r_in_byte),
        .i_index         (r_in_index),
        .i_begin         (r_in_begin),
        .i_last          (r_in_last),
        .i_is_stop       (is_stop),
        .o_verdict       (verdict),
        .o_scan_start    (scan_start),
        .o_atom_start    (atom_start),
        .o_atom_length   (atom_length),
        .o_error_index   (error_index),
        .o_next_position (next_position)
    );

    // Hold the result until taken; a free slot loads the next verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= verdict.emit;
        end else if (o_tok.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && verdict.emit) begin
            r_out_success       <= verdict.success;
            r_out_kind          <= verdict.kind;
            r_out_status        <= verdict.status;
            r_out_scan_start    <= scan_start;
            r_out_atom_start    <= atom_start;
            r_out_atom_length   <= atom_length;
            r_out_error_index   <= error_index;
            r_out_next_position <= next_position;
        end
    end

    assign o_tok.valid            = r_out_valid;
    assign o_tok.success          = r_out_success;
    assign o_tok.kind             = r_out_kind;
    assign o_tok.status           = r_out_status;
    assign o_tok.scan_start_index = r_out_scan_start;
    assign o_tok.atom_start_index = r_out_atom_start;
    assign o_tok.atom_length      = r_out_atom_length;
    assign o_tok.error_index      = r_out_error_index;
    assign o_tok.next_position    = r_out_next_position;

    `ATC_ASSERT_NOW(a_ok_clean, i_clk, i_rst_n, r_out_valid && r_out_success,
        (r_out_status == ST_OK) && (r_out_error_index == '0) && (r_out_kind != KIND_NONE),
        "successful token carries an error field")
    `ATC_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, r_out_valid && !r_out_success,
        (r_out_kind == KIND_NONE) && (r_out_atom_length == '0) && (r_out_status != ST_OK),
        "failed scan carries token fields")
    `ATC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in_index) && $stable(r_in_byte),
        "stalled input word lost or changed")

endmodule

/* sv/atc_stop_cfg.sv */
// Configuration registers and stop symbol matcher.
module atc_stop_cfg #(
    parameter int STOP_ENTRIES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [atc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [atc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic [7:0]                        i_byte,
    output logic                              o_is_stop
);
    import atc_pkg::*;

    logic [STOP_CNT_BITS-1:0] r_stop_count;
    logic [7:0]               r_stop_tab [STOP_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= '0;
        end else if (i_cfg_we && (i_cfg_index == CFG_STOP_COUNT)) begin
            r_stop_count <= i_cfg_data[STOP_CNT_BITS-1:0];
        end
    end

    // Entries past the register map are never written and hold zero.
    for (genvar e = 0; e < STOP_ENTRIES; e++) begin : g_tab
        if (e < STOP_REGS) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stop_tab[e] <= '0;
                end else if (i_cfg_we &&
                             (i_cfg_index == CFG_IDX_BITS'(int'(CFG_STOP_SYM_A) + e))) begin
                    r_stop_tab[e] <= i_cfg_data[7:0];
                end
            end
        end else begin : g_zero
            assign r_stop_tab[e] = '0;
        end
    end

    // Counts above the table size simply enable every entry.
    always_comb begin
        o_is_stop = 1'b0;
        for (int i = 0; i < STOP_ENTRIES; i++) begin
            if ((i < int'(r_stop_count)) && (r_stop_tab[i] == i_byte)) begin
                o_is_stop = 1'b1;
            end
        end
    end

endmodule

/* sv/atc_scan_core.sv */
// Scan state registers and per-byte atom classification.
module atc_scan_core #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    input  logic [INDEX_BITS-1:0] i_index,
    input  logic                  i_begin,
    input  logic                  i_last,
    input  logic                  i_is_stop,
    output atc_pkg::t_verdict     o_verdict,
    output logic [INDEX_BITS-1:0] o_scan_start,
    output logic [INDEX_BITS-1:0] o_atom_start,
    output logic [INDEX_BITS:0]   o_atom_length,
    output logic [INDEX_BITS:0]   o_error_index,
    output logic [INDEX_BITS:0]   o_next_position
);
    import atc_pkg::*;

    t_phase                r_phase, n_phase;
    logic [INDEX_BITS-1:0] r_scan_origin, n_scan_origin;
    logic [INDEX_BITS-1:0] r_atom_origin, n_atom_origin;

    t_phase                ph;
    t_phase                ph_next;
    logic                  space_c;
    logic                  digit_c;
    logic                  brk_c;
    t_verdict              v;
    logic [INDEX_BITS:0]   fail_where;
    logic [INDEX_BITS-1:0] diff;
    logic [INDEX_BITS:0]   idx_ext;

    assign space_c = is_space(i_byte);
    assign digit_c = is_decimal(i_byte);
    assign brk_c   = space_c || i_is_stop;
    assign idx_ext = {1'b0, i_index};

    always_comb begin
        ph            = i_begin ? PH_SKIP : r_phase;
        n_scan_origin = i_begin ? i_index : r_scan_origin;
        n_atom_origin = r_atom_origin;
        ph_next       = ph;
        v             = '{emit: 1'b0, success: 1'b0, kind: KIND_NONE,
                          status: ST_OK, inclusive: 1'b0};
        fail_where    = idx_ext;

        unique case (ph)
            PH_SKIP: begin
                if (space_c) begin
                    if (i_last) begin
                        v.emit     = 1'b1;
                        v.status   = ST_EXHAUSTED;
                        fail_where = idx_ext + (INDEX_BITS+1)'(1);
                    end
                end else if (i_is_stop) begin
                    v.emit   = 1'b1;
                    v.status = ST_STOP_FIRST;
                end else begin
                    n_atom_origin = i_index;
                    if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                        ph_next = PH_SIGN;
                    end else if (digit_c) begin
                        ph_next = PH_INT;
                    end else begin
                        ph_next = PH_SYM;
                    end
                    if (i_last) begin
                        v.emit      = 1'b1;
                        v.success   = 1'b1;
                        v.kind      = kind_of(ph_next);
                        v.inclusive = 1'b1;
                    end
                end
            end
            PH_SIGN: begin
                if (brk_c) begin
                    v.emit    = 1'b1;
                    v.success = 1'b1;
                    v.kind    = KIND_SYM;
                end else begin
                    ph_next = digit_c ? PH_INT : PH_SYM;
                    if (i_last) begin
                        v.emit      = 1'b1;
                        v.success   = 1'b1;
                        v.kind      = kind_of(ph_next);
                        v.inclusive = 1'b1;
                    end
                end
            end
            PH_INT, PH_REAL, PH_SYM: begin
                if (brk_c) begin
                    v.emit    = 1'b1;
                    v.success = 1'b1;
                    v.kind    = kind_of(ph);
                end else if ((ph == PH_INT) && !digit_c && (i_byte != CH_DOT)) begin
                    v.emit   = 1'b1;
                    v.status = ST_BAD_NUMBER;
                end else if ((ph == PH_REAL) && !digit_c) begin
                    v.emit   = 1'b1;
                    v.status = ST_BAD_NUMBER;
                end else begin
                    if ((ph == PH_INT) && (i_byte == CH_DOT)) begin
                        ph_next = PH_REAL;
                    end
                    if (i_last) begin
                        v.emit      = 1'b1;
                        v.success   = 1'b1;
                        v.kind      = kind_of(ph_next);
                        v.inclusive = 1'b1;
                    end
                end
            end
            default: begin
                // idle or decided: drop the byte
            end
        endcase

        n_phase = v.emit ? PH_DONE : ph_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_scan_origin <= '0;
            r_atom_origin <= '0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_scan_origin <= n_scan_origin;
            r_atom_origin <= n_atom_origin;
        end
    end

    assign diff            = i_index - n_atom_origin;
    assign o_verdict       = v;
    assign o_scan_start    = n_scan_origin;
    assign o_atom_start    = v.success ? n_atom_origin : '0;
    assign o_atom_length   = v.success ?
                             ({1'b0, diff} + (INDEX_BITS+1)'(v.inclusive)) : '0;
    assign o_error_index   = v.success ? '0 : fail_where;
    assign o_next_position = v.success ?
                             (idx_ext + (INDEX_BITS+1)'(v.inclusive)) : '0;

endmodule
